// ===== rtl/biou_pkg.sv =====
`default_nettype none

package biou_pkg;

   localparam int unsigned FRAC_BITS  = 16;
   localparam int unsigned RATIO_BITS = FRAC_BITS + 1;
   localparam int unsigned THR_BITS   = 17;

   localparam logic [THR_BITS-1:0]   THR_RESET = 17'd32768;
   localparam logic [RATIO_BITS-1:0] RATIO_ONE = 17'd65536;

   typedef struct packed {
      logic is_match;
      logic degenerate;
   } flags_type;

endpackage

`default_nettype wire

// ===== rtl/biou_geom.sv =====
`default_nettype none

module biou_geom #(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [COORD_BITS-1:0]   ref_xmin,
   input  logic [COORD_BITS-1:0]   ref_ymin,
   input  logic [COORD_BITS-1:0]   ref_xmax,
   input  logic [COORD_BITS-1:0]   ref_ymax,
   input  logic [COORD_BITS-1:0]   cand_xmin,
   input  logic [COORD_BITS-1:0]   cand_ymin,
   input  logic [COORD_BITS-1:0]   cand_xmax,
   input  logic [COORD_BITS-1:0]   cand_ymax,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [2*COORD_BITS-1:0] inter_area,
   output logic [2*COORD_BITS-1:0] ref_area,
   output logic [2*COORD_BITS:0]   uni_area,
   output logic                    degen
);

   localparam int unsigned CW = COORD_BITS;
   localparam int unsigned AW = 2 * CW + 2;
   localparam int unsigned UW = 2 * CW + 3;

   logic en1, en2, en3;

   // stage 1: intersection extents and box sides
   logic [CW-1:0] x_lo, x_hi, y_lo, y_hi;
   logic [CW:0]   x_dif, y_dif;
   logic [CW-1:0] ix_in, iy_in;
   logic [CW:0]   rw_in, rh_in, cw_in, ch_in;
   logic          s1_valid_ff;
   logic [CW-1:0] ix_ff, iy_ff;
   logic [CW:0]   rw_ff, rh_ff, cw_ff, ch_ff;

   always_comb begin
      x_lo  = (ref_xmin > cand_xmin) ? ref_xmin : cand_xmin;
      x_hi  = (ref_xmax < cand_xmax) ? ref_xmax : cand_xmax;
      y_lo  = (ref_ymin > cand_ymin) ? ref_ymin : cand_ymin;
      y_hi  = (ref_ymax < cand_ymax) ? ref_ymax : cand_ymax;
      x_dif = {1'b0, x_hi} - {1'b0, x_lo};
      y_dif = {1'b0, y_hi} - {1'b0, y_lo};
      // clamp a negative overlap to zero
      ix_in = x_dif[CW] ? '0 : x_dif[CW-1:0];
      iy_in = y_dif[CW] ? '0 : y_dif[CW-1:0];
      rw_in = {1'b0, ref_xmax} - {1'b0, ref_xmin};
      rh_in = {1'b0, ref_ymax} - {1'b0, ref_ymin};
      cw_in = {1'b0, cand_xmax} - {1'b0, cand_xmin};
      ch_in = {1'b0, cand_ymax} - {1'b0, cand_ymin};
   end

   // stage 2: areas
   logic [2*CW-1:0] inter_in;
   logic [AW-1:0]   ref_in, cand_in;
   logic            s2_valid_ff;
   logic [2*CW-1:0] inter2_ff;
   logic [AW-1:0]   ref2_ff, cand2_ff;

   always_comb begin
      inter_in = {{CW{1'b0}}, ix_ff} * {{CW{1'b0}}, iy_ff};
      ref_in   = $signed({{(CW+1){rw_ff[CW]}}, rw_ff}) *
                 $signed({{(CW+1){rh_ff[CW]}}, rh_ff});
      cand_in  = $signed({{(CW+1){cw_ff[CW]}}, cw_ff}) *
                 $signed({{(CW+1){ch_ff[CW]}}, ch_ff});
   end

   // stage 3: union and degenerate check
   logic [UW-1:0]   uni_in;
   logic            degen_in;
   logic            s3_valid_ff;
   logic [2*CW-1:0] inter3_ff, ref3_ff;
   logic [2*CW:0]   union3_ff;
   logic            degen3_ff;

   always_comb begin
      uni_in   = {ref2_ff[AW-1], ref2_ff} + {cand2_ff[AW-1], cand2_ff} -
                 {3'b000, inter2_ff};
      degen_in = ref2_ff[AW-1] || (ref2_ff == '0) || uni_in[UW-1] || (uni_in == '0);
   end

   assign en3      = !s3_valid_ff || out_ready;
   assign en2      = !s2_valid_ff || en3;
   assign en1      = !s1_valid_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= in_valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         ix_ff <= ix_in;
         iy_ff <= iy_in;
         rw_ff <= rw_in;
         rh_ff <= rh_in;
         cw_ff <= cw_in;
         ch_ff <= ch_in;
      end
      if (en2) begin
         inter2_ff <= inter_in;
         ref2_ff   <= ref_in;
         cand2_ff  <= cand_in;
      end
      if (en3) begin
         inter3_ff <= inter2_ff;
         ref3_ff   <= ref2_ff[2*CW-1:0];
         union3_ff <= uni_in[2*CW:0];
         degen3_ff <= degen_in;
      end
   end

   assign out_valid  = s3_valid_ff;
   assign inter_area = inter3_ff;
   assign ref_area   = ref3_ff;
   assign uni_area   = union3_ff;
   assign degen      = degen3_ff;

endmodule

`default_nettype wire

// ===== rtl/biou_match.sv =====
`default_nettype none

module biou_match #(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [biou_pkg::THR_BITS-1:0] threshold,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [2*COORD_BITS-1:0]       inter_area,
   input  logic [2*COORD_BITS-1:0]       ref_area,
   input  logic [2*COORD_BITS:0]         uni_area,
   input  logic                          degen,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [2*COORD_BITS-1:0]       dividend,
   output logic [2*COORD_BITS-1:0]       divisor,
   output biou_pkg::flags_type           flags
);

   import biou_pkg::*;

   localparam int unsigned CW   = COORD_BITS;
   localparam int unsigned NW   = 2 * CW;
   localparam int unsigned PW   = 2 * CW + 1 + THR_BITS;
   localparam int unsigned LPAD = PW - NW - FRAC_BITS;

   logic ena, enb;

   // stage A: threshold times union
   logic [PW-1:0] prod_in;
   logic          a_valid_ff;
   logic [PW-1:0] prod_ff;
   logic [NW-1:0] inter_a_ff, ref_a_ff;
   logic          degen_a_ff;

   assign prod_in = {{(NW+1){1'b0}}, threshold} * {{THR_BITS{1'b0}}, uni_area};

   // stage B: compare inter * 2^16 against it, prepare divider operands
   logic [PW-1:0] lhs;
   flags_type     flags_in;
   logic [NW-1:0] dividend_in, divisor_in;
   logic          b_valid_ff;
   logic [NW-1:0] dividend_ff, divisor_ff;
   flags_type     flags_ff;

   always_comb begin
      lhs                 = {{LPAD{1'b0}}, inter_a_ff, {FRAC_BITS{1'b0}}};
      flags_in.degenerate = degen_a_ff;
      flags_in.is_match   = !degen_a_ff && (lhs > prod_ff);
      // force a zero quotient for a degenerate pair
      dividend_in         = degen_a_ff ? '0 : inter_a_ff;
      divisor_in          = degen_a_ff ? {{(NW-1){1'b0}}, 1'b1} : ref_a_ff;
   end

   assign enb      = !b_valid_ff || out_ready;
   assign ena      = !a_valid_ff || enb;
   assign in_ready = ena;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (ena) a_valid_ff <= in_valid;
         if (enb) b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ena) begin
         prod_ff    <= prod_in;
         inter_a_ff <= inter_area;
         ref_a_ff   <= ref_area;
         degen_a_ff <= degen;
      end
      if (enb) begin
         dividend_ff <= dividend_in;
         divisor_ff  <= divisor_in;
         flags_ff    <= flags_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign dividend  = dividend_ff;
   assign divisor   = divisor_ff;
   assign flags     = flags_ff;

endmodule

`default_nettype wire

// ===== rtl/biou_div.sv =====
`default_nettype none

module biou_div #(
   parameter int unsigned WIDTH = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [WIDTH-1:0]                dividend,
   input  logic [WIDTH-1:0]                divisor,
   input  biou_pkg::flags_type             flags_in,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [biou_pkg::RATIO_BITS-1:0] quotient,
   output biou_pkg::flags_type             flags_out
);

   import biou_pkg::*;

   // one quotient bit per stage; the dividend never exceeds the divisor,
   // so the top bit needs no shift and every remainder stays below the divisor
   localparam int unsigned NSTG = RATIO_BITS;

   logic                  v_ff   [NSTG];
   logic [WIDTH-1:0]      rem_ff [NSTG];
   logic [WIDTH-1:0]      dvs_ff [NSTG];
   logic [RATIO_BITS-1:0] q_ff   [NSTG];
   flags_type             flg_ff [NSTG];
   logic                  en     [NSTG+1];

   assign en[NSTG] = out_ready;

   genvar j;
   generate
      for (j = 0; j < NSTG; j++) begin : g_stage
         logic                  v_prev;
         logic [WIDTH:0]        trial;
         logic [WIDTH-1:0]      dvs_prev;
         logic [RATIO_BITS-1:0] q_prev;
         flags_type             flg_prev;
         logic [WIDTH:0]        diff;
         logic                  qbit;
         logic [WIDTH-1:0]      rem_in;
         logic [RATIO_BITS-1:0] q_in;

         if (j == 0) begin : g_first
            assign v_prev   = in_valid;
            assign trial    = {1'b0, dividend};
            assign dvs_prev = divisor;
            assign q_prev   = '0;
            assign flg_prev = flags_in;
         end else begin : g_next
            assign v_prev   = v_ff[j-1];
            assign trial    = {rem_ff[j-1], 1'b0};
            assign dvs_prev = dvs_ff[j-1];
            assign q_prev   = q_ff[j-1];
            assign flg_prev = flg_ff[j-1];
         end

         always_comb begin
            diff   = trial - {1'b0, dvs_prev};
            qbit   = (trial >= {1'b0, dvs_prev});
            rem_in = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            q_in   = {q_prev[RATIO_BITS-2:0], qbit};
         end

         assign en[j] = !v_ff[j] || en[j+1];

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[j] <= 1'b0;
            end else if (en[j]) begin
               v_ff[j] <= v_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (en[j]) begin
               rem_ff[j] <= rem_in;
               dvs_ff[j] <= dvs_prev;
               q_ff[j]   <= q_in;
               flg_ff[j] <= flg_prev;
            end
         end
      end
   endgenerate

   assign in_ready  = en[0];
   assign out_valid = v_ff[NSTG-1];
   assign quotient  = q_ff[NSTG-1];
   assign flags_out = flg_ff[NSTG-1];

endmodule

`default_nettype wire

// ===== rtl/box_iou_threshold_label.sv =====
// Box overlap scorer: compares a reference box with a candidate box.
// Request channel (req_valid/req_ready) carries both boxes as corner
// coordinates; response channel (rsp_valid/rsp_ready) returns the match
// label, the intersection over reference-area ratio (Q1.16, max 1.0) and
// a degenerate flag. The csr channel writes the Q1.16 IoU threshold; it is
// always ready and should only be written while no request is in flight.
// Throughput: one request per cycle, sustained while rsp_ready stays high.
// Pipeline: 22 register stages: three stages of extents, areas and union,
// two stages of threshold multiply and compare, and seventeen stages of a
// restoring divider, one ratio bit per stage.
// Each stage advances when it is empty or the next one advances, so when
// the receiver stalls the results stay put, empty slots upstream still
// fill, and req_ready drops only once the whole pipeline is full.
// Reset (synchronous) empties the pipeline and sets the threshold to 0.5.
`default_nettype none

module box_iou_threshold_label #(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [biou_pkg::THR_BITS-1:0]   csr_iou_threshold,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [COORD_BITS-1:0]           req_ref_xmin,
   input  logic [COORD_BITS-1:0]           req_ref_ymin,
   input  logic [COORD_BITS-1:0]           req_ref_xmax,
   input  logic [COORD_BITS-1:0]           req_ref_ymax,
   input  logic [COORD_BITS-1:0]           req_cand_xmin,
   input  logic [COORD_BITS-1:0]           req_cand_ymin,
   input  logic [COORD_BITS-1:0]           req_cand_xmax,
   input  logic [COORD_BITS-1:0]           req_cand_ymax,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_is_match,
   output logic [biou_pkg::RATIO_BITS-1:0] rsp_overlap_ratio,
   output logic                            rsp_degenerate
);

   import biou_pkg::*;

   localparam int unsigned NW = 2 * COORD_BITS;

   logic [THR_BITS-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_iou_threshold;
      end
   end

   assign csr_ready = 1'b1;

   logic          geo_valid, geo_ready;
   logic [NW-1:0] geo_inter, geo_ref;
   logic [NW:0]   geo_union;
   logic          geo_degen;

   biou_geom #(
      .COORD_BITS (COORD_BITS)
   ) u_geom (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .ref_xmin   (req_ref_xmin),
      .ref_ymin   (req_ref_ymin),
      .ref_xmax   (req_ref_xmax),
      .ref_ymax   (req_ref_ymax),
      .cand_xmin  (req_cand_xmin),
      .cand_ymin  (req_cand_ymin),
      .cand_xmax  (req_cand_xmax),
      .cand_ymax  (req_cand_ymax),
      .out_valid  (geo_valid),
      .out_ready  (geo_ready),
      .inter_area (geo_inter),
      .ref_area   (geo_ref),
      .uni_area   (geo_union),
      .degen      (geo_degen)
   );

   logic          cmp_valid, cmp_ready;
   logic [NW-1:0] cmp_dividend, cmp_divisor;
   flags_type     cmp_flags;

   biou_match #(
      .COORD_BITS (COORD_BITS)
   ) u_match (
      .clock      (clock),
      .reset      (reset),
      .threshold  (thr_ff),
      .in_valid   (geo_valid),
      .in_ready   (geo_ready),
      .inter_area (geo_inter),
      .ref_area   (geo_ref),
      .uni_area   (geo_union),
      .degen      (geo_degen),
      .out_valid  (cmp_valid),
      .out_ready  (cmp_ready),
      .dividend   (cmp_dividend),
      .divisor    (cmp_divisor),
      .flags      (cmp_flags)
   );

   flags_type out_flags;

   biou_div #(
      .WIDTH (NW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cmp_valid),
      .in_ready  (cmp_ready),
      .dividend  (cmp_dividend),
      .divisor   (cmp_divisor),
      .flags_in  (cmp_flags),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .quotient  (rsp_overlap_ratio),
      .flags_out (out_flags)
   );

   assign rsp_is_match   = out_flags.is_match;
   assign rsp_degenerate = out_flags.degenerate;

   a_degen_clears : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> (rsp_overlap_ratio == '0) && !rsp_is_match)
      else $error("degenerate response carries a ratio or a match");

   a_ratio_cap : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_overlap_ratio <= RATIO_ONE)
      else $error("overlap ratio above one");

   a_thr_reset : assert property (@(posedge clock)
      reset |=> thr_ff == THR_RESET)
      else $error("threshold not at its reset value after reset");

endmodule

`default_nettype wire
